/* sv/cwt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types, character codes and the operation letter lookup for the
// cigar word to text converter.
// ----------------------------------------------------------------------------
package cwt_pkg;

	localparam int RUN_LENGTH_W = 28;
	localparam int OP_W         = 4;
	localparam int CHAR_W       = 7;
	localparam int NUM_OPS      = 10;

	localparam logic [OP_W-1:0]   OP_MAX     = 4'd9;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
	localparam logic [CHAR_W-1:0] ASCII_QMARK = 7'h3F;

	// M I D N S H P = X B
	localparam logic [CHAR_W-1:0] OP_LETTERS [NUM_OPS] = '{
		7'h4D, 7'h49, 7'h44, 7'h4E, 7'h53, 7'h48, 7'h50, 7'h3D, 7'h58, 7'h42
	};

	typedef struct packed {
		logic [OP_W-1:0] op_code;
		logic            final_element;
	} cwt_meta_t;

	function automatic logic op_is_bad(input logic [OP_W-1:0] op);
		return op > OP_MAX;
	endfunction

	function automatic logic [CHAR_W-1:0] op_char(input logic [OP_W-1:0] op);
		logic [CHAR_W-1:0] ch;
		if (op_is_bad(op)) begin
			ch = ASCII_QMARK;
		end else begin
			ch = OP_LETTERS[op];
		end
		return ch;
	endfunction

endpackage

/* sv/cwt_dabble.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_dabble
// Bit-serial binary to BCD converter: shift-and-add-3, one length bit per
// cycle, result held until the emitter takes it.
// ----------------------------------------------------------------------------
module cwt_dabble #(
	parameter int LENGTH_BITS = 28,
	parameter int DIGITS      = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [LENGTH_BITS-1:0] length_in,
	input  cwt_pkg::cwt_meta_t     meta_in,
	output logic                   idle,
	output logic                   bcd_valid,
	input  logic                   bcd_take,
	output logic [4*DIGITS-1:0]    bcd,
	output cwt_pkg::cwt_meta_t     meta
);
	import cwt_pkg::*;

	localparam int BCD_W = 4 * DIGITS;
	localparam int CNT_W = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [LENGTH_BITS-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	cwt_meta_t          meta_q;
	logic [BCD_W-1:0]   corr;
	logic               digits_ok;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		corr      = bcd_q;
		digits_ok = 1'b1;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				corr[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
			if (bcd_q[4*i +: 4] > 4'd9) begin
				digits_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bin_q   <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
			meta_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						bin_q   <= length_in;
						meta_q  <= meta_in;
						bcd_q   <= '0;
						cnt_q   <= CNT_W'(LENGTH_BITS - 1);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					bin_q <= bin_q << 1;
					bcd_q <= {corr[BCD_W-2:0], bin_q[LENGTH_BITS-1]};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (bcd_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign bcd_valid = (state_q == ST_HOLD);
	assign bcd       = bcd_q;
	assign meta      = meta_q;

	a_start_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		start && idle |=> state_q == ST_SHIFT && cnt_q == CNT_W'(LENGTH_BITS - 1))
		else $error("converter did not begin shifting after start");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_valid |-> digits_ok)
		else $error("converted result holds a non-decimal digit");

	a_hold_until_taken: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_valid && !bcd_take |=> bcd_valid && $stable(bcd_q))
		else $error("held result changed before it was taken");

endmodule

/* sv/cwt_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_emit
// Digit shifter: drops leading zeros, then sends one ASCII digit per beat,
// most significant first, followed by the operation letter.
// ----------------------------------------------------------------------------
module cwt_emit #(
	parameter int DIGITS = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load_valid,
	output logic                         load_ready,
	input  logic [4*DIGITS-1:0]          load_bcd,
	input  cwt_pkg::cwt_meta_t           load_meta,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cwt_pkg::CHAR_W-1:0]   char_code,
	output logic                         last_of_run,
	output logic                         end_of_record,
	output logic                         bad_op
);
	import cwt_pkg::*;

	localparam int BCD_W = 4 * DIGITS;
	localparam int REM_W = $clog2(DIGITS + 1);

	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_SKIP,
		ST_DIGIT,
		ST_LETTER
	} state_t;

	state_t           state_q;
	logic [BCD_W-1:0] dig_q;
	logic [REM_W-1:0] rem_q;
	cwt_meta_t        meta_q;
	logic [3:0]       top_digit;
	logic             one_left;

	assign top_digit = dig_q[BCD_W-1 -: 4];
	assign one_left  = (rem_q == REM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
			dig_q   <= '0;
			rem_q   <= '0;
			meta_q  <= '0;
		end else begin
			unique case (state_q)
				ST_EMPTY: begin
					if (load_valid) begin
						dig_q   <= load_bcd;
						meta_q  <= load_meta;
						rem_q   <= REM_W'(DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// keep at least one digit so zero prints as '0'
					if (top_digit == 4'd0 && !one_left) begin
						dig_q <= dig_q << 4;
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_ready) begin
						dig_q <= dig_q << 4;
						rem_q <= rem_q - REM_W'(1);
						if (one_left) begin
							state_q <= ST_LETTER;
						end
					end
				end
				ST_LETTER: begin
					if (out_ready) begin
						state_q <= ST_EMPTY;
					end
				end
				default: state_q <= ST_EMPTY;
			endcase
		end
	end

	assign load_ready    = (state_q == ST_EMPTY);
	assign out_valid     = (state_q == ST_DIGIT) || (state_q == ST_LETTER);
	assign last_of_run   = (state_q == ST_LETTER);
	assign end_of_record = last_of_run && meta_q.final_element;
	assign bad_op        = last_of_run && op_is_bad(meta_q.op_code);
	assign char_code     = last_of_run ? op_char(meta_q.op_code)
	                                   : ASCII_ZERO + {3'b000, top_digit};

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> char_code >= ASCII_ZERO && char_code <= ASCII_NINE)
		else $error("digit beat carries a non-digit character");

	a_letter_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGIT && out_ready && one_left |=> last_of_run)
		else $error("letter did not follow the last digit");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_SKIP) && state_q == ST_DIGIT && !one_left
		|-> top_digit != 4'd0)
		else $error("leading zero left in front of a multi-digit run length");

endmodule

/* sv/cigar_word_to_text.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_word_to_text
// Turns one cigar element (run length, operation code) into its text form:
// decimal digits without leading zeros, then the operation letter.
//
//   channel | handshake            | beat
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | run_length, op_code, final_element
//   out     | out_valid / out_ready| char_code, last_of_run, end_of_record,
//           |                      | bad_op (one character per beat)
//
// Each element is accepted into the bit-serial BCD converter, shifted through
// it bit by bit and then held for handoff; the digit shifter then loads it,
// drops leading zeros, sends one beat per digit and then the letter.
// The converter takes the next element while the shifter still sends, so
// conversion of one element overlaps sending of the one before.
// Reset clears both state machines; a stalled output holds the shifter
// and the converter then waits in hold.
// ----------------------------------------------------------------------------
module cigar_word_to_text #(
	parameter int LENGTH_BITS = 28
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cwt_pkg::RUN_LENGTH_W-1:0]   run_length,
	input  logic [cwt_pkg::OP_W-1:0]           op_code,
	input  logic                               final_element,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cwt_pkg::CHAR_W-1:0]         char_code,
	output logic                               last_of_run,
	output logic                               end_of_record,
	output logic                               bad_op
);
	import cwt_pkg::*;

	// decimal digits needed for 2^LENGTH_BITS - 1
	localparam int DIGITS = ((LENGTH_BITS * 1233) >> 12) + 1;

	cwt_meta_t             meta_in;
	cwt_meta_t             meta_cv;
	logic                  cv_idle;
	logic                  bcd_valid;
	logic                  bcd_take;
	logic [4*DIGITS-1:0]   bcd;

	assign meta_in.op_code       = op_code;
	assign meta_in.final_element = final_element;
	assign in_ready              = cv_idle;

	cwt_dabble #(
		.LENGTH_BITS (LENGTH_BITS),
		.DIGITS      (DIGITS)
	) u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.length_in (run_length[LENGTH_BITS-1:0]),
		.meta_in   (meta_in),
		.idle      (cv_idle),
		.bcd_valid (bcd_valid),
		.bcd_take  (bcd_take),
		.bcd       (bcd),
		.meta      (meta_cv)
	);

	logic load_ready;
	assign bcd_take = bcd_valid && load_ready;

	cwt_emit #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_valid    (bcd_valid),
		.load_ready    (load_ready),
		.load_bcd      (bcd),
		.load_meta     (meta_cv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_code     (char_code),
		.last_of_run   (last_of_run),
		.end_of_record (end_of_record),
		.bad_op        (bad_op)
	);

	a_flags_on_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (end_of_record || bad_op) |-> last_of_run)
		else $error("record or bad-op flag on a digit beat");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_take |=> !bcd_valid && !load_ready)
		else $error("converter to shifter handoff lost or repeated");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_of_run))
		else $error("output beat changed while stalled");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cigar_word_to_text. Elements are sent on the input
// channel and an in-bench model predicts the character beats of each one:
// decimal digits with no leading zeros, then the operation letter with its
// last-of-run, end-of-record and bad-op marks. A checker compares each output
// beat with the oldest prediction. Both sides idle at random, the receiver
// also holds off for a long stretch, and the sender pauses to drain.
// ----------------------------------------------------------------------------
module testbench;

	import cwt_pkg::*;

	localparam int  LEN_BITS       = 28;
	localparam int  CLK_HALF       = 6;
	localparam int  LIMIT_CYCLES   = 400000;
	localparam int  SETTLE_CYCLES  = 64;
	localparam int  IDLE_PERCENT   = 17;
	localparam int  RANDOM_ITEMS   = 210;

	localparam logic [OP_W-1:0] OP_MATCH  = 4'd0;
	localparam logic [OP_W-1:0] OP_INS    = 4'd1;
	localparam logic [OP_W-1:0] OP_DEL    = 4'd2;
	localparam logic [OP_W-1:0] OP_SKIP   = 4'd3;
	localparam logic [OP_W-1:0] OP_SOFT   = 4'd4;
	localparam logic [OP_W-1:0] OP_HARD   = 4'd5;
	localparam logic [OP_W-1:0] OP_PAD    = 4'd6;
	localparam logic [OP_W-1:0] OP_EQUAL  = 4'd7;
	localparam logic [OP_W-1:0] OP_DIFF   = 4'd8;
	localparam logic [OP_W-1:0] OP_BACK   = 4'd9;
	localparam logic [OP_W-1:0] OP_TOP    = 4'd15;

	// letters in op code order, first letter in the top byte
	localparam logic [8*10-1:0] OP_TEXT = "MIDNSHP=XB";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              eor;
		logic              bad;
	} text_beat_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [RUN_LENGTH_W-1:0] run_length;
	logic [OP_W-1:0]         op_code;
	logic                    final_element;
	logic                    out_valid;
	logic                    out_ready;
	logic [CHAR_W-1:0]       char_code;
	logic                    last_of_run;
	logic                    end_of_record;
	logic                    bad_op;

	text_beat_t expected_chars[$];
	int         errors;
	int         cycle_count;
	int         hold_cycles;
	bit         quiet;

	cigar_word_to_text #(
		.LENGTH_BITS(LEN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.run_length(run_length),
		.op_code(op_code),
		.final_element(final_element),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.last_of_run(last_of_run),
		.end_of_record(end_of_record),
		.bad_op(bad_op)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	function automatic void predict_text(input logic [RUN_LENGTH_W-1:0] len,
			input logic [OP_W-1:0] op, input logic fin);
		logic [3:0]  digits[10];
		int          nd;
		longint      rest;
		text_beat_t  beat;
		rest = len & ((64'd1 << LEN_BITS) - 1);
		nd = 0;
		do begin
			digits[nd] = 4'(rest % 10);
			rest = rest / 10;
			nd++;
		end while (rest != 0 && nd < 10);
		while (nd > 0) begin
			nd--;
			beat = '{ch: ASCII_ZERO + CHAR_W'(digits[nd]), last: 1'b0, eor: 1'b0,
				bad: 1'b0};
			expected_chars.push_back(beat);
		end
		if (op > OP_BACK) begin
			beat = '{ch: ASCII_QMARK, last: 1'b1, eor: fin, bad: 1'b1};
		end else begin
			beat = '{ch: CHAR_W'(OP_TEXT[8 * (9 - int'(op)) +: 8]), last: 1'b1,
				eor: fin, bad: 1'b0};
		end
		expected_chars.push_back(beat);
	endfunction

	function automatic int idle_gap();
		int gap;
		gap = 0;
		while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			gap++;
		end
		return gap;
	endfunction

	function automatic logic [RUN_LENGTH_W-1:0] random_length();
		logic [RUN_LENGTH_W-1:0] len;
		int                      k;
		case ($urandom_range(3))
			0: begin
				len = RUN_LENGTH_W'($urandom);
			end
			1: begin
				len = RUN_LENGTH_W'($urandom_range(0, 99));
			end
			2: begin
				k = $urandom_range(1, 8);
				len = RUN_LENGTH_W'(10 ** k - $urandom_range(0, 1));
			end
			default: begin
				len = RUN_LENGTH_W'($urandom) >> $urandom_range(0, RUN_LENGTH_W - 1);
			end
		endcase
		return len;
	endfunction

	// holds the beat until accepted; valid stays high between back to back beats
	task automatic send_element(input logic [RUN_LENGTH_W-1:0] len,
			input logic [OP_W-1:0] op, input logic fin);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		run_length    <= len;
		op_code       <= op;
		final_element <= fin;
		do @(posedge clk); while (!in_ready);
		predict_text(len, op, fin);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) begin
			send_element(random_length(),
				($urandom_range(99) < 80) ? OP_W'($urandom_range(0, OP_BACK))
					: OP_W'($urandom_range(OP_BACK + 1, OP_TOP)),
				1'($urandom));
		end
	endtask

	task automatic test_directed();
		for (int op = OP_MATCH; op <= OP_TOP; op++) begin
			send_element('0, OP_W'(op), 1'(op));
		end
		send_element('1, OP_BACK, 1'b1);
		send_element(RUN_LENGTH_W'(1), OP_INS, 1'b0);
		send_element(RUN_LENGTH_W'(9), OP_DEL, 1'b0);
		send_element(RUN_LENGTH_W'(10), OP_SOFT, 1'b1);
		send_element(RUN_LENGTH_W'(268), OP_SKIP, 1'b0);
		send_element(RUN_LENGTH_W'(5), OP_PAD, 1'b1);
		send_element(RUN_LENGTH_W'(99999999), OP_EQUAL, 1'b0);
		send_element(RUN_LENGTH_W'(100000000), OP_DIFF, 1'b1);
		send_element(RUN_LENGTH_W'(200000000), OP_TOP, 1'b0);
	endtask

	task automatic test_random();
		send_random(RANDOM_ITEMS);
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		send_random(60);
		quiet = 1'b0;
	endtask

	task automatic test_output_hold();
		hold_cycles = 400;
		quiet = 1'b1;
		send_random(40);
		quiet = 1'b0;
	endtask

	task automatic test_drain_pause();
		wait_drained();
		send_element(RUN_LENGTH_W'(123456789), OP_MATCH, 1'b1);
		send_element('0, OP_HARD, 1'b0);
		wait_drained();
		send_random(20);
	endtask

	// receiver readiness, with an optional long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		text_beat_t got;
		text_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{ch: char_code, last: last_of_run, eor: end_of_record, bad: bad_op};
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual ch %h last %b eor %b bad %b",
					$time, got.ch, got.last, got.eor, got.bad);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (got.ch !== want.ch) begin
					$display("%0t: char_code expected %h actual %h", $time, want.ch, got.ch);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last_of_run expected %b actual %b", $time, want.last,
						got.last);
					errors++;
				end
				if (got.eor !== want.eor) begin
					$display("%0t: end_of_record expected %b actual %b", $time, want.eor,
						got.eor);
					errors++;
				end
				if (got.bad !== want.bad) begin
					$display("%0t: bad_op expected %b actual %b", $time, want.bad, got.bad);
					errors++;
				end
			end
		end
	end

	initial begin
		errors        = 0;
		cycle_count   = 0;
		hold_cycles   = 0;
		quiet         = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		run_length    = '0;
		op_code       = '0;
		final_element = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();
		test_back_to_back();
		test_output_hold();
		test_drain_pause();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_chars.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

/* files.f */
sv/cwt_pkg.sv
sv/cwt_dabble.sv
sv/cwt_emit.sv
sv/cigar_word_to_text.sv
test/testbench.sv
